// ===== rtl/kpr_pkg.sv =====
// Shared types and constants for the key long-press / auto-repeat detector.
// No dependencies.
`default_nettype none

package kpr_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd2;

    localparam logic [LIMIT_W-1:0] SINGLE_RST = 16'd50;
    localparam logic [LIMIT_W-1:0] LONG_RST   = 16'd1000;
    localparam logic [LIMIT_W-1:0] REPEAT_RST = 16'd200;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_LONG   = 2'd2,
        EV_REPEAT = 2'd3
    } kpr_event_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_PRESSED = 4'b0010,
        PH_LONG    = 4'b0100,
        PH_REPEAT  = 4'b1000
    } kpr_phase_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] single_press_ms;
        logic [LIMIT_W-1:0] long_press_ms;
        logic [LIMIT_W-1:0] repeat_ms;
    } kpr_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/kpr_fsm.sv =====
// Phase machine and transition timer of the key detector.
// Depends on kpr_pkg.
`default_nettype none

module kpr_fsm import kpr_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire logic              key_down,
    input  wire kpr_cfg_t          cfg,
    output kpr_event_t             event_code
);

    kpr_phase_t          phase_reg, phase_next;
    logic [TIME_W-1:0]   mark_reg, mark_next;
    logic [TIME_W-1:0]   elapsed;
    logic [LIMIT_W-1:0]  limit;
    kpr_phase_t          adv_phase;
    kpr_event_t          adv_event;
    logic                expired;

    // modulo 2^32 difference, so clock wrap is harmless
    assign elapsed = now_ms - mark_reg;
    assign expired = elapsed > {{(TIME_W-LIMIT_W){1'b0}}, limit};

    always_comb begin
        unique case (phase_reg)
            PH_PRESSED: begin
                limit = cfg.single_press_ms;
                adv_phase = PH_LONG;
                adv_event = EV_SINGLE;
            end
            PH_LONG: begin
                limit = cfg.long_press_ms;
                adv_phase = PH_REPEAT;
                adv_event = EV_LONG;
            end
            PH_REPEAT: begin
                limit = cfg.repeat_ms;
                adv_phase = PH_REPEAT;
                adv_event = EV_REPEAT;
            end
            default: begin
                limit = '0;
                adv_phase = PH_IDLE;
                adv_event = EV_NONE;
            end
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        mark_next  = mark_reg;
        event_code = EV_NONE;
        if (phase_reg == PH_IDLE) begin
            if (key_down) begin
                phase_next = PH_PRESSED;
                mark_next  = now_ms;
            end
        end else if (expired) begin
            if (key_down) begin
                phase_next = adv_phase;
                mark_next  = now_ms;
                event_code = adv_event;
            end else begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            mark_reg  <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            mark_reg  <= mark_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_IDLE |-> event_code == EV_NONE)
        else $error("event reported from idle");

    a_event_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        step && event_code != EV_NONE |=> mark_reg == $past(now_ms))
        else $error("timer not restarted on event");

    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(phase_reg) && $stable(mark_reg))
        else $error("state changed without a poll");
`endif

endmodule

`default_nettype wire

// ===== rtl/key_press_longpress_repeat_core.sv =====
// Result path: each poll passes the input register, then the result register.
// Throughput: one poll per cycle unless a result waits on m_ready; phase/timer loop is registered.
// Reset: aresetn synchronous, active low; phase idle, mark time 0,
// hold times 50/1000/200 ms, both pipeline registers empty.
// Depends on kpr_pkg and kpr_fsm.
`default_nettype none

module key_press_longpress_repeat_core import kpr_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [TIME_W-1:0]    s_now_ms,
    input  wire logic                 s_key_down,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_event_res,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LIMIT_W-1:0]   cfg_wdata
);

    kpr_cfg_t            cfg_reg;
    logic                in_valid_reg;
    logic [TIME_W-1:0]   in_now_reg;
    logic                in_key_reg;
    logic                out_valid_reg;
    kpr_event_t          out_event_reg;
    kpr_event_t          event_code;
    logic                advance;

    // the held poll moves on when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.single_press_ms <= SINGLE_RST;
            cfg_reg.long_press_ms   <= LONG_RST;
            cfg_reg.repeat_ms       <= REPEAT_RST;
        end else if (cfg_we) begin
            if (cfg_index == CFG_SINGLE) cfg_reg.single_press_ms <= cfg_wdata;
            if (cfg_index == CFG_LONG)   cfg_reg.long_press_ms   <= cfg_wdata;
            if (cfg_index == CFG_REPEAT) cfg_reg.repeat_ms       <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_now_reg <= s_now_ms;
            in_key_reg <= s_key_down;
        end
    end

    kpr_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .now_ms     (in_now_reg),
        .key_down   (in_key_reg),
        .cfg        (cfg_reg),
        .event_code (event_code)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= event_code;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_event_res = out_event_reg;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for key_press_longpress_repeat_core.
// It sends a table of polls, then random press sequences under several hold-time settings.
// Each result is checked against the table answer or a predictor in this file. Depends on kpr_pkg and the core RTL.

module tb_top;
    import kpr_pkg::*;

    // Spare register index: writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int unsigned N_PHASES  = 6;
    localparam int unsigned PHASE_LEN = 238;
    localparam int unsigned DRAIN_CYC = 8;

    typedef struct {
        logic [TIME_W-1:0] now_ms;
        logic              key_down;
        bit                known;      // event_res below is the answer; else predicted
        kpr_event_t        event_res;
    } poll_row_t;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [TIME_W-1:0]    s_now_ms    = '0;
    logic                 s_key_down  = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [1:0]           m_event_res;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_SINGLE;
    logic [LIMIT_W-1:0]   cfg_wdata   = '0;

    // Predictor state
    kpr_phase_t        key_phase;
    logic [TIME_W-1:0] mark_ms;
    kpr_cfg_t          hold_cfg;

    kpr_event_t        event_q [$];
    kpr_event_t        want_event;
    logic [TIME_W-1:0] clock_ms;
    int unsigned       idle_pct = 0;
    int unsigned       n_polls  = 0;
    int unsigned       n_fail   = 0;
    int unsigned       event_tally [4] = '{0, 0, 0, 0};

    // Defaults are 50/1000/200 ms until the first register write
    poll_row_t press_script [22] = '{
        '{32'h0000_0000, 1'b0, 1'b1, EV_NONE},    // idle, released
        '{32'd100,       1'b1, 1'b1, EV_NONE},    // press starts the timer
        '{32'd150,       1'b1, 1'b1, EV_NONE},    // exactly 50 ms: not yet
        '{32'd151,       1'b1, 1'b1, EV_SINGLE},
        '{32'd1151,      1'b0, 1'b1, EV_NONE},    // released but time not passed
        '{32'd1152,      1'b1, 1'b1, EV_LONG},
        '{32'd1352,      1'b1, 1'b1, EV_NONE},
        '{32'd1353,      1'b1, 1'b1, EV_REPEAT},
        '{32'd1554,      1'b1, 1'b1, EV_REPEAT},
        '{32'd1755,      1'b0, 1'b1, EV_NONE},    // release after timeout -> idle
        '{32'hFFFF_FFF0, 1'b1, 1'b1, EV_NONE},
        '{32'h0000_0022, 1'b1, 1'b1, EV_NONE},    // 50 ms across the wrap
        '{32'h0000_0023, 1'b1, 1'b1, EV_SINGLE},
        '{32'h0000_0010, 1'b1, 1'b1, EV_LONG},    // time going backwards
        '{32'hFFFF_FFFF, 1'b0, 1'b1, EV_NONE},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, EV_NONE},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, EV_NONE},
        '{32'h0000_0000, 1'b0, 1'b1, EV_NONE},
        '{32'h0000_0033, 1'b1, 1'b1, EV_SINGLE},
        '{32'h8000_0000, 1'b0, 1'b1, EV_NONE},
        '{32'h5555_5555, 1'b1, 1'b0, EV_NONE},
        '{32'hAAAA_AAAA, 1'b1, 1'b0, EV_NONE}
    };

    key_press_longpress_repeat_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_now_ms    (s_now_ms),
        .s_key_down  (s_key_down),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [TIME_W-1:0] phase_limit();
        case (key_phase)
            PH_PRESSED: return {16'h0, hold_cfg.single_press_ms};
            PH_LONG:    return {16'h0, hold_cfg.long_press_ms};
            PH_REPEAT:  return {16'h0, hold_cfg.repeat_ms};
            default:    return '0;
        endcase
    endfunction

    // Advances the predicted key state by one poll, returns the event it reports
    function automatic kpr_event_t next_event(input logic [TIME_W-1:0] now, input logic key);
        logic [TIME_W-1:0] since;
        kpr_event_t        ev;
        since = now - mark_ms;
        ev = EV_NONE;
        if (key_phase == PH_IDLE) begin
            if (key) begin
                key_phase = PH_PRESSED;
                mark_ms = now;
            end
        end else if (since > phase_limit()) begin
            if (key) begin
                case (key_phase)
                    PH_PRESSED: begin
                        key_phase = PH_LONG;
                        ev = EV_SINGLE;
                    end
                    PH_LONG: begin
                        key_phase = PH_REPEAT;
                        ev = EV_LONG;
                    end
                    default: ev = EV_REPEAT;
                endcase
                mark_ms = now;
            end else begin
                key_phase = PH_IDLE;
            end
        end
        return ev;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_SINGLE: hold_cfg.single_press_ms = data;
            CFG_LONG:   hold_cfg.long_press_ms   = data;
            CFG_REPEAT: hold_cfg.repeat_ms       = data;
            default: ;
        endcase
    endtask

    task automatic send_poll(input logic [TIME_W-1:0] now, input logic key,
                             input bit known, input kpr_event_t given);
        kpr_event_t ev;
        s_valid    <= 1'b1;
        s_now_ms   <= now;
        s_key_down <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ev = next_event(now, key);
        event_q.push_back(known ? given : ev);
        n_polls++;
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // Block idle: input stopped, every result back, pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        while (event_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    // Press runs with time steps aimed at the current hold limit, plus noise
    task automatic run_random(input int unsigned n);
        logic [TIME_W-1:0] lim;
        logic [TIME_W-1:0] now;
        logic              key;
        int unsigned       hold_left;
        int unsigned       r;
        hold_left = 0;
        for (int unsigned i = 0; i < n; i++) begin
            lim = phase_limit();
            r = $urandom_range(0, 99);
            if (hold_left > 0) begin
                key = ($urandom_range(0, 99) < 92);
                hold_left--;
            end else begin
                key = ($urandom_range(0, 99) < 8);
                if ($urandom_range(0, 99) < 35)
                    hold_left = $urandom_range(1, 14);
            end
            if (r < 5) begin
                now = $urandom;
                key = 1'($urandom_range(0, 1));
            end else begin
                if (r < 8) begin
                    clock_ms -= $urandom_range(1, 70000);
                end else begin
                    case ($urandom_range(0, 4))
                        0:       clock_ms += lim;
                        1:       clock_ms += lim + 1;
                        2:       clock_ms += $urandom_range(0, lim / 4 + 2);
                        3:       clock_ms += $urandom_range(0, 2 * lim + 3);
                        default: ;
                    endcase
                end
                now = clock_ms;
            end
            send_poll(now, key, 1'b0, EV_NONE);
        end
    endtask

    initial begin
        int unsigned       stall_len;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 99) < idle_pct) begin
                stall_len = $urandom_range(1, 15);
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (event_q.size() == 0) begin
                $error("event_res: no result expected, got %0d", m_event_res);
                n_fail++;
            end else begin
                want_event = event_q.pop_front();
                if (m_event_res !== want_event) begin
                    $error("event_res: expected %0d, got %0d", want_event, m_event_res);
                    n_fail++;
                end
            end
            if (!$isunknown(m_event_res))
                event_tally[m_event_res]++;
        end
    end

    initial begin
        logic [LIMIT_W-1:0] hold_set [3];
        int unsigned        phase_idle [N_PHASES];

        phase_idle = '{30, 10, 0, 20, 10, 0};
        key_phase = PH_IDLE;
        mark_ms   = '0;
        hold_cfg  = '{single_press_ms: SINGLE_RST, long_press_ms: LONG_RST,
                      repeat_ms: REPEAT_RST};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_pct = 15;
        foreach (press_script[i])
            send_poll(press_script[i].now_ms, press_script[i].key_down,
                      press_script[i].known, press_script[i].event_res);
        settle();

        for (int unsigned p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       hold_set = '{16'h0000, 16'h0000, 16'h0000};
                1:       hold_set = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
                2:       hold_set = '{16'h0000, 16'hFFFF, 16'h0001};
                3, 4: begin
                    foreach (hold_set[k])
                        hold_set[k] = LIMIT_W'($urandom_range(0, 40));
                end
                default: begin
                    foreach (hold_set[k])
                        hold_set[k] = LIMIT_W'($urandom);
                end
            endcase
            cfg_write(CFG_SINGLE, hold_set[0]);
            cfg_write(CFG_LONG,   hold_set[1]);
            cfg_write(CFG_REPEAT, hold_set[2]);
            if (p % 3 == 0)
                cfg_write(CFG_SPARE, LIMIT_W'($urandom));
            cfg_we <= 1'b0;
            @(posedge aclk);

            idle_pct = phase_idle[p];
            clock_ms = (p == 2) ? 32'hFFFF_0000 : $urandom;
            run_random(PHASE_LEN);
            settle();
        end

        $display("%0d polls checked over %0d hold-time settings, wrap and backward time included",
                 n_polls, N_PHASES + 1);
        $display("events seen: %0d single, %0d long, %0d repeat, %0d none",
                 event_tally[EV_SINGLE], event_tally[EV_LONG],
                 event_tally[EV_REPEAT], event_tally[EV_NONE]);
        if (n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
